[hw/rtl/crc8fd_pkg.sv]
// ----------------------------------------------------------------------------
// crc8fd_pkg
// Shared widths, codes, types and the CRC-8 byte update for the frame
// deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package crc8fd_pkg;

  // Width of the decoded length field (7 to 15).
  localparam int LENGTH_BITS = 15;
  localparam logic [14:0] LEN_MASK = 15'((1 << LENGTH_BITS) - 1);

  localparam logic [7:0] LONG_FLAG = 8'h80;
  localparam logic [7:0] HIGH_MASK = 8'h7f;

  // Configuration port.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 15;

  localparam logic [CFG_INDEX_W-1:0] REG_SYNC_NIBBLE  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CRC_POLY     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CRC_INIT     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_PAYLOAD  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ACCEPTED_CMD = 3'd4;

  // Result status codes.
  localparam logic [2:0] ST_BUSY    = 3'd0;
  localparam logic [2:0] ST_READY   = 3'd1;
  localparam logic [2:0] ST_CRC_ERR = 3'd2;
  localparam logic [2:0] ST_BAD_CMD = 3'd3;
  localparam logic [2:0] ST_BAD_LEN = 3'd4;

  typedef struct packed {
    logic [3:0]  sync_nibble;
    logic [7:0]  crc_poly;
    logic [7:0]  crc_init;
    logic [14:0] max_payload;
    logic [3:0]  accepted_cmd;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  frame_cmd;
    logic [7:0]  frame_id;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [14:0] payload_index;
    logic [14:0] payload_length;
  } res_t;

  // MSB-first CRC-8 over one byte, implicit x^8 term.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc,
                                             input logic [7:0] data,
                                             input logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ poly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/crc8fd_cfg.sv]
// ----------------------------------------------------------------------------
// crc8fd_cfg
// Configuration registers of the deframer, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module crc8fd_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [crc8fd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [crc8fd_pkg::CFG_DATA_W-1:0]  cfg_data,
  output crc8fd_pkg::cfg_t                        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_nibble  <= 4'd10;
      cfg.crc_poly     <= 8'd7;
      cfg.crc_init     <= 8'd0;
      cfg.max_payload  <= 15'd248;
      cfg.accepted_cmd <= 4'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        crc8fd_pkg::REG_SYNC_NIBBLE:  cfg.sync_nibble  <= cfg_data[3:0];
        crc8fd_pkg::REG_CRC_POLY:     cfg.crc_poly     <= cfg_data[7:0];
        crc8fd_pkg::REG_CRC_INIT:     cfg.crc_init     <= cfg_data[7:0];
        crc8fd_pkg::REG_MAX_PAYLOAD:  cfg.max_payload  <= cfg_data[14:0];
        crc8fd_pkg::REG_ACCEPTED_CMD: cfg.accepted_cmd <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/crc8fd_parser.sv]
// ----------------------------------------------------------------------------
// crc8fd_parser
// Frame state and the per-byte decode: sync, id, length, payload and CRC.
// ----------------------------------------------------------------------------
`default_nettype none

module crc8fd_parser (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire logic [7:0]        rx_byte,
  input  wire crc8fd_pkg::cfg_t  cfg,
  output crc8fd_pkg::res_t       res
);

  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_ID      = 3'd1;
  localparam logic [2:0] PH_LEN_HI  = 3'd2;
  localparam logic [2:0] PH_LEN_LO  = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_CRC     = 3'd5;

  logic [2:0]  phase, phase_next;
  logic [7:0]  running_crc, running_crc_next;
  logic [7:0]  held_id, held_id_next;
  logic [3:0]  held_cmd, held_cmd_next;
  logic [6:0]  length_high, length_high_next;
  logic [14:0] frame_length, frame_length_next;
  logic [14:0] bytes_seen, bytes_seen_next;

  logic [7:0]  crc_upd;
  logic [14:0] len_dec;
  logic [2:0]  status;

  // The CRC seed is the configured start value only on the sync byte, which is
  // taken while hunting or in any phase code without a meaning.
  assign crc_upd = crc8fd_pkg::crc8_update((phase == PH_HUNT || phase > PH_CRC) ?
                                           cfg.crc_init : running_crc,
                                           rx_byte, cfg.crc_poly);

  always_comb begin
    if (phase == PH_LEN_LO) begin
      len_dec = {length_high, rx_byte} & crc8fd_pkg::LEN_MASK;
    end else begin
      len_dec = {7'd0, rx_byte} & crc8fd_pkg::LEN_MASK;
    end
  end

  always_comb begin
    phase_next        = phase;
    running_crc_next  = running_crc;
    held_id_next      = held_id;
    held_cmd_next     = held_cmd;
    length_high_next  = length_high;
    frame_length_next = frame_length;
    bytes_seen_next   = bytes_seen;
    status            = crc8fd_pkg::ST_BUSY;
    res.payload_valid = 1'b0;
    res.payload_byte  = 8'd0;
    res.payload_index = 15'd0;

    unique case (phase) inside
      PH_ID: begin
        held_id_next     = rx_byte;
        running_crc_next = crc_upd;
        phase_next       = PH_LEN_HI;
      end
      PH_LEN_HI, PH_LEN_LO: begin
        running_crc_next = crc_upd;
        if (phase == PH_LEN_HI && (rx_byte & crc8fd_pkg::LONG_FLAG) != 8'd0) begin
          length_high_next = rx_byte[6:0] & crc8fd_pkg::HIGH_MASK[6:0];
          phase_next       = PH_LEN_LO;
        end else begin
          frame_length_next = len_dec;
          if (len_dec > cfg.max_payload) begin
            status = crc8fd_pkg::ST_BAD_LEN;
          end else begin
            phase_next = (len_dec == 15'd0) ? PH_CRC : PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        res.payload_valid = 1'b1;
        res.payload_byte  = rx_byte;
        res.payload_index = bytes_seen;
        running_crc_next  = crc_upd;
        bytes_seen_next   = bytes_seen + 15'd1;
        if (bytes_seen_next >= frame_length) begin
          phase_next = PH_CRC;
        end
      end
      PH_CRC: begin
        if (running_crc != rx_byte) begin
          status = crc8fd_pkg::ST_CRC_ERR;
        end else if (held_cmd == cfg.accepted_cmd) begin
          status = crc8fd_pkg::ST_READY;
        end else begin
          status = crc8fd_pkg::ST_BAD_CMD;
        end
      end
      default: begin
        // Hunting, and any phase code without a meaning.
        if (rx_byte[7:4] == cfg.sync_nibble) begin
          held_cmd_next    = rx_byte[3:0];
          running_crc_next = crc_upd;
          phase_next       = PH_ID;
        end else begin
          phase_next        = PH_HUNT;
          running_crc_next  = 8'd0;
          held_id_next      = 8'd0;
          held_cmd_next     = 4'd0;
          length_high_next  = 7'd0;
          frame_length_next = 15'd0;
          bytes_seen_next   = 15'd0;
        end
      end
    endcase

    // The result reports the frame as it stands before any final clear.
    res.status         = status;
    res.frame_cmd      = held_cmd_next;
    res.frame_id       = held_id_next;
    res.payload_length = frame_length_next;

    if (status != crc8fd_pkg::ST_BUSY) begin
      phase_next        = PH_HUNT;
      running_crc_next  = 8'd0;
      held_id_next      = 8'd0;
      held_cmd_next     = 4'd0;
      length_high_next  = 7'd0;
      frame_length_next = 15'd0;
      bytes_seen_next   = 15'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      running_crc  <= 8'd0;
      held_id      <= 8'd0;
      held_cmd     <= 4'd0;
      length_high  <= 7'd0;
      frame_length <= 15'd0;
      bytes_seen   <= 15'd0;
    end else if (step) begin
      phase        <= phase_next;
      running_crc  <= running_crc_next;
      held_id      <= held_id_next;
      held_cmd     <= held_cmd_next;
      length_high  <= length_high_next;
      frame_length <= frame_length_next;
      bytes_seen   <= bytes_seen_next;
    end
  end

`ifndef SYNTHESIS
  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    step && res.status != crc8fd_pkg::ST_BUSY |=> phase == PH_HUNT && bytes_seen == 15'd0)
    else $error("final status did not return the parser to hunting");

  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    step && res.payload_valid |-> res.payload_index < res.payload_length)
    else $error("payload index beyond decoded length");

  a_payload_phase: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> frame_length != 15'd0 && bytes_seen < frame_length)
    else $error("payload phase with no bytes left");
`endif

endmodule

`default_nettype wire

[hw/rtl/crc8_frame_deframer_core.sv]
// ----------------------------------------------------------------------------
// crc8_frame_deframer_core
// Byte-serial deframer for sync / id / length / payload / CRC-8 frames, with
// one status result per received byte.
// ----------------------------------------------------------------------------
//  Channel  Direction  Signals                     Contents
//  s_*      in         s_tvalid s_tready s_tdata   one received byte
//  m_*      out        m_tvalid m_tready m_tdata   status, frame and payload info
//                      m_tuser                     payload flag
//  cfg_*    in         cfg_we cfg_index cfg_data   register writes, no read-back
//
// One byte is accepted per cycle unless the output stalls; its result is
// offered on m_* once it has passed the input register and then the result
// register.
// The CRC-8 update and length compare are combinational.
// Reset is synchronous; it empties both registers and returns the parser to
// hunting with the register defaults loaded.
// A stalled result holds in the output register while the next byte can still
// enter the input register if that register is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module crc8_frame_deframer_core (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [7:0]                         s_tdata,  // rx_byte
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // status[2:0], frame_cmd[6:3], frame_id[14:7], payload_byte[22:15],
  // payload_index[37:23], payload_length[52:38], zero fill[55:53]
  output logic [55:0]                             m_tdata,
  output logic                                    m_tuser,  // payload_valid
  input  wire logic                               cfg_we,
  input  wire logic [crc8fd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [crc8fd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  crc8fd_pkg::cfg_t cfg;
  crc8fd_pkg::res_t res;
  crc8fd_pkg::res_t out_res;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       advance;

  // The held byte moves on whenever the result register is free or draining.
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  crc8fd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  crc8fd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .rx_byte (in_byte),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_tdata = {3'd0, out_res.payload_length, out_res.payload_index,
                    out_res.payload_byte, out_res.frame_id, out_res.frame_cmd,
                    out_res.status};
  assign m_tuser = out_res.payload_valid;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !advance)
    else $error("result overwritten while stalled");

  a_input_kept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_byte))
    else $error("held byte lost before it was parsed");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> out_res.status <= crc8fd_pkg::ST_BAD_LEN)
    else $error("status code out of range");
`endif

endmodule

`default_nettype wire

[bench/tb_crc8_frame_deframer_core.sv]
// ----------------------------------------------------------------------------
// tb_crc8_frame_deframer_core
// Self-checking bench for the byte-serial CRC-8 frame deframer. A software
// copy of the parser predicts the status result of every accepted byte, and
// each result leaving the block is compared field by field with the oldest
// prediction. Directed frames and register masking checks come first, then
// frames at and just past the payload limit, a long output stall and several
// phases of random frames and noise under varied register settings.
// ----------------------------------------------------------------------------
module tb_crc8_frame_deframer_core;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    P_HUNT, P_ID, P_LEN_HI, P_LEN_LO, P_PAYLOAD, P_CRC
  } parse_phase_t;

  logic                               clk       = 1'b0;
  logic                               rst       = 1'b1;
  logic                               s_tvalid  = 1'b0;
  logic                               s_tready;
  logic [7:0]                         s_tdata   = 8'h00;
  logic                               m_tvalid;
  logic                               m_tready  = 1'b0;
  logic [55:0]                        m_tdata;
  logic                               m_tuser;
  logic                               cfg_we    = 1'b0;
  logic [crc8fd_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [crc8fd_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

  // Register copy and parser state of the predictor.
  crc8fd_pkg::cfg_t shadow = '{sync_nibble: 4'd10, crc_poly: 8'd7, crc_init: 8'd0,
                               max_payload: 15'd248, accepted_cmd: 4'd1};
  parse_phase_t ph       = P_HUNT;
  logic [7:0]   run_crc  = 8'h00;
  logic [7:0]   cur_id   = 8'h00;
  logic [3:0]   cur_cmd  = 4'h0;
  logic [6:0]   len_high = 7'h00;
  logic [14:0]  cur_len  = 15'h0000;
  logic [14:0]  seen     = 15'h0000;

  crc8fd_pkg::res_t due_results[$];
  int   mismatch_count   = 0;
  int   frame_bytes_sent = 0;
  bit   idle_on          = 1'b1;
  int   long_stall       = 0;

  crc8_frame_deframer_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),    // rx_byte
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),    // status, frame_cmd, frame_id, payload_byte,
                             // payload_index, payload_length
    .m_tuser   (m_tuser),    // payload_valid
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic int idle_gap();
    return idle_on ? int'($urandom_range(0, 4)) : 0;
  endfunction

  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    repeat (8) c = c[7] ? ((c << 1) ^ shadow.crc_poly) : (c << 1);
    return c;
  endfunction

  task automatic clear_parse();
    ph       = P_HUNT;
    run_crc  = 8'h00;
    cur_id   = 8'h00;
    cur_cmd  = 4'h0;
    len_high = 7'h00;
    cur_len  = 15'h0000;
    seen     = 15'h0000;
  endtask

  task automatic take_length(input logic [14:0] len, output logic [2:0] st);
    cur_len = len & crc8fd_pkg::LEN_MASK;
    if (cur_len > shadow.max_payload) begin
      st = crc8fd_pkg::ST_BAD_LEN;
    end else begin
      st = crc8fd_pkg::ST_BUSY;
      ph = (cur_len == 15'd0) ? P_CRC : P_PAYLOAD;
    end
  endtask

  // Advances the parser copy by one byte and queues the status it should give.
  task automatic parse_byte(input logic [7:0] b);
    crc8fd_pkg::res_t r;
    logic [2:0]       st;
    logic             pv;
    logic [7:0]       pb;
    logic [14:0]      pi;
    st = crc8fd_pkg::ST_BUSY;
    pv = 1'b0;
    pb = 8'h00;
    pi = 15'h0000;
    case (ph)
      P_ID: begin
        cur_id  = b;
        run_crc = crc_step(run_crc, b);
        ph      = P_LEN_HI;
      end
      P_LEN_HI: begin
        run_crc = crc_step(run_crc, b);
        if ((b & crc8fd_pkg::LONG_FLAG) != 8'h00) begin
          len_high = 7'(b & crc8fd_pkg::HIGH_MASK);
          ph       = P_LEN_LO;
        end else begin
          take_length(15'(b), st);
        end
      end
      P_LEN_LO: begin
        run_crc = crc_step(run_crc, b);
        take_length({len_high, b}, st);
      end
      P_PAYLOAD: begin
        pv      = 1'b1;
        pb      = b;
        pi      = seen;
        run_crc = crc_step(run_crc, b);
        seen    = seen + 15'd1;
        if (seen >= cur_len) ph = P_CRC;
      end
      P_CRC: begin
        if (run_crc != b) st = crc8fd_pkg::ST_CRC_ERR;
        else if (cur_cmd == shadow.accepted_cmd) st = crc8fd_pkg::ST_READY;
        else st = crc8fd_pkg::ST_BAD_CMD;
      end
      default: begin
        if (b[7:4] == shadow.sync_nibble) begin
          cur_cmd = b[3:0];
          run_crc = crc_step(shadow.crc_init, b);
          ph      = P_ID;
        end else begin
          clear_parse();
        end
      end
    endcase
    r.status         = st;
    r.frame_cmd      = cur_cmd;
    r.frame_id       = cur_id;
    r.payload_valid  = pv;
    r.payload_byte   = pb;
    r.payload_index  = pi;
    r.payload_length = cur_len;
    due_results.push_back(r);
    if (st != crc8fd_pkg::ST_BUSY) clear_parse();
  endtask

  // Entered and left just after a falling edge; valid stays high between
  // back-to-back requests.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    if (ph != P_HUNT || b[7:4] == shadow.sync_nibble) frame_bytes_sent++;
    parse_byte(b);
    @(negedge clk);
  endtask

  // Feeds bytes until the parser copy is hunting again; zero bytes keep any
  // length picked up here at zero.
  task automatic flush_to_hunt();
    while (ph != P_HUNT)
      send_byte((ph == P_PAYLOAD || ph == P_CRC) ? 8'($urandom_range(0, 255)) : 8'h00);
  endtask

  task automatic send_frame(input logic [3:0] cmd, input logic [7:0] id, input int len,
                            input bit long_form, input bit bad_crc, input bit truncate);
    logic [7:0] bytes[$];
    logic [7:0] crc;
    int         n;
    bytes.push_back({shadow.sync_nibble, cmd});
    bytes.push_back(id);
    if (long_form) begin
      bytes.push_back(crc8fd_pkg::LONG_FLAG | 8'(len >> 8));
      bytes.push_back(8'(len));
    end else begin
      bytes.push_back(8'(len));
    end
    // A frame whose length is over the limit ends on its length byte.
    if (len <= int'(shadow.max_payload)) begin
      repeat (len) bytes.push_back(8'($urandom_range(0, 255)));
      crc = shadow.crc_init;
      foreach (bytes[i]) crc = crc_step(crc, bytes[i]);
      if (bad_crc) crc ^= 8'($urandom_range(1, 255));
      bytes.push_back(crc);
    end
    n = truncate ? int'($urandom_range(1, bytes.size() - 1)) : bytes.size();
    for (int i = 0; i < n; i++) send_byte(bytes[i]);
    flush_to_hunt();
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [crc8fd_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [crc8fd_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      crc8fd_pkg::REG_SYNC_NIBBLE:  shadow.sync_nibble  = val[3:0];
      crc8fd_pkg::REG_CRC_POLY:     shadow.crc_poly     = val[7:0];
      crc8fd_pkg::REG_CRC_INIT:     shadow.crc_init     = val[7:0];
      crc8fd_pkg::REG_MAX_PAYLOAD:  shadow.max_payload  = val[14:0];
      crc8fd_pkg::REG_ACCEPTED_CMD: shadow.accepted_cmd = val[3:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input crc8fd_pkg::cfg_t c);
    settle();
    write_reg(crc8fd_pkg::REG_SYNC_NIBBLE, 15'(c.sync_nibble));
    write_reg(crc8fd_pkg::REG_CRC_POLY, 15'(c.crc_poly));
    write_reg(crc8fd_pkg::REG_CRC_INIT, 15'(c.crc_init));
    write_reg(crc8fd_pkg::REG_MAX_PAYLOAD, c.max_payload);
    write_reg(crc8fd_pkg::REG_ACCEPTED_CMD, 15'(c.accepted_cmd));
  endtask

  task automatic random_frame();
    int         len;
    int         r;
    int         cap;
    bit         long_form;
    bit         bad_crc;
    bit         truncate;
    logic [3:0] cmd;
    r   = $urandom_range(0, 99);
    cap = (shadow.max_payload < 15'd24) ? int'(shadow.max_payload) : 24;
    if (r < 12 && shadow.max_payload < 15'h7fff) begin
      len = int'(shadow.max_payload) + 1 + int'($urandom_range(0, 40));
      if (len > 32767) len = 32767;
    end else if (r < 17 && shadow.max_payload <= 15'd300) begin
      len = int'(shadow.max_payload);
    end else begin
      len = $urandom_range(0, cap);
    end
    long_form = (len > 127) || ($urandom_range(0, 3) == 0);
    cmd       = ($urandom_range(0, 9) < 6) ? shadow.accepted_cmd : 4'($urandom_range(0, 15));
    bad_crc   = $urandom_range(0, 99) < 12;
    truncate  = $urandom_range(0, 99) < 8;
    send_frame(cmd, 8'($urandom_range(0, 255)), len, long_form, bad_crc, truncate);
  endtask

  task automatic test_directed_frames();
    send_byte(8'h00);
    send_byte(8'hff);
    send_frame(4'h1, 8'hff, 0, 1'b0, 1'b0, 1'b0);
    send_frame(4'h0, 8'h00, 1, 1'b0, 1'b0, 1'b0);
    send_frame(4'h1, 8'h5a, 0, 1'b0, 1'b1, 1'b0);
    // A bad CRC wins over an unknown command.
    send_frame(4'h0, 8'h81, 0, 1'b0, 1'b1, 1'b0);
    // The widest two-byte length is over the limit and ends the frame.
    send_frame(4'h1, 8'ha5, 32767, 1'b1, 1'b0, 1'b0);
    // Zero length in the two-byte form goes straight to the CRC byte.
    send_frame(4'h1, 8'h7e, 0, 1'b1, 1'b0, 1'b0);
  endtask

  task automatic test_register_masking();
    settle();
    write_reg(crc8fd_pkg::REG_SYNC_NIBBLE, 15'h7ff5);
    write_reg(crc8fd_pkg::REG_CRC_POLY, 15'h7f31);
    write_reg(crc8fd_pkg::REG_CRC_INIT, 15'h7aff);
    write_reg(crc8fd_pkg::REG_MAX_PAYLOAD, 15'h7fff);
    write_reg(crc8fd_pkg::REG_ACCEPTED_CMD, 15'h7ffa);
    // Indexes past the last register must change nothing.
    for (int i = int'(crc8fd_pkg::REG_ACCEPTED_CMD) + 1; i < (1 << crc8fd_pkg::CFG_INDEX_W);
         i++)
      write_reg(i[crc8fd_pkg::CFG_INDEX_W-1:0], 15'h7fff);
    send_frame(4'ha, 8'h42, 3, 1'b0, 1'b0, 1'b0);
    send_frame(4'h3, 8'hc3, 2, 1'b1, 1'b0, 1'b0);
  endtask

  task automatic test_longest_frame();
    settle();
    write_reg(crc8fd_pkg::REG_MAX_PAYLOAD, 15'd300);
    idle_on = 1'b0;
    // A payload exactly at the limit, then a length one past it.
    send_frame(shadow.accepted_cmd, 8'h3c, 300, 1'b1, 1'b0, 1'b0);
    send_frame(shadow.accepted_cmd, 8'h3d, 301, 1'b1, 1'b0, 1'b0);
    idle_on = 1'b1;
  endtask

  task automatic test_back_pressure();
    settle();
    idle_on    = 1'b0;
    long_stall = 150;
    repeat (6) send_frame(shadow.accepted_cmd, 8'($urandom_range(0, 255)),
                          $urandom_range(4, 10), 1'b0, 1'b0, 1'b0);
    idle_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    crc8fd_pkg::cfg_t c;
    int               target;
    for (int k = 0; k < 6; k++) begin
      case (k)
        0: c = '{sync_nibble: 4'h0, crc_poly: 8'h00, crc_init: 8'h00,
                 max_payload: 15'd0, accepted_cmd: 4'h0};
        1: c = '{sync_nibble: 4'hf, crc_poly: 8'hff, crc_init: 8'hff,
                 max_payload: 15'h7fff, accepted_cmd: 4'hf};
        2: c = '{sync_nibble: 4'($urandom_range(0, 15)), crc_poly: 8'h31,
                 crc_init: 8'($urandom_range(0, 255)), max_payload: 15'd248,
                 accepted_cmd: 4'($urandom_range(0, 15))};
        default: c = '{sync_nibble: 4'($urandom_range(0, 15)),
                       crc_poly: 8'($urandom_range(0, 255)),
                       crc_init: 8'($urandom_range(0, 255)),
                       max_payload: 15'($urandom_range(1, 40)),
                       accepted_cmd: 4'($urandom_range(0, 15))};
      endcase
      apply_config(c);
      idle_on = (k != 3);
      target  = frame_bytes_sent + 80;
      while (frame_bytes_sent < target) begin
        if ($urandom_range(0, 99) < 12) begin
          send_byte(8'($urandom_range(0, 255)));
          flush_to_hunt();
        end else begin
          random_frame();
        end
      end
    end
    idle_on = 1'b1;
  endtask

  // Receiver: a random hold-off before every result while idle gaps are on, or a long one on request.
  initial begin : result_sink
    int gap;
    while (rst) @(negedge clk);
    forever begin
      if (long_stall > 0) begin
        gap        = long_stall;
        long_stall = 0;
      end else begin
        gap = idle_gap();
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
      @(negedge clk);
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    crc8fd_pkg::res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (due_results.size() == 0) begin
        $error("result with no prediction waiting: status %0d", m_tdata[2:0]);
        mismatch_count++;
      end else begin
        want = due_results.pop_front();
        check_field("status", want.status, m_tdata[2:0]);
        check_field("frame_cmd", want.frame_cmd, m_tdata[6:3]);
        check_field("frame_id", want.frame_id, m_tdata[14:7]);
        check_field("payload_valid", want.payload_valid, m_tuser);
        check_field("payload_byte", want.payload_byte, m_tdata[22:15]);
        check_field("payload_index", want.payload_index, m_tdata[37:23]);
        check_field("payload_length", want.payload_length, m_tdata[52:38]);
      end
    end
  end

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    test_directed_frames();
    test_register_masking();
    test_longest_frame();
    test_back_pressure();
    test_random_traffic();
    settle();
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #250_000;
    $display("Verification failed");
    $finish;
  end

endmodule
